FILE: hw/rtl/sle_pkg.sv
// Shared constants, codes and controller/datapath interface types for the sorted list engine.
package sle_pkg;

    // Store geometry
    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int VALUE_W = 32;
    localparam int OCC_W   = 5;

    // Operation codes carried by the kind field
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_LIST   = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic take_in;     // latch the accepted transfer
        logic do_insert;   // run the insert and load its status result
        logic do_remove;   // run the remove and load its status result
        logic emit_empty;  // load the empty-list result
        logic start_list;  // rewind the readout index
        logic emit_entry;  // load the entry under the readout index
        logic inc_idx;     // step the readout index
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] kind;       // kind of the held item
        logic       count_zero; // store is empty
        logic       idx_last;   // readout index is on the last entry
    } t_stat;

endpackage

FILE: hw/rtl/sorted_list_engine.sv
// Top level of the sorted list engine: controller and datapath.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------------
//  in      | input     | i_in_valid / o_in_stall  | i_kind, i_value
//  out     | output    | o_out_valid / i_out_stall| o_out_value, o_occupancy, o_status, o_last
//
// An insert or remove is latched into the holding register, then compared against all
// cells in parallel to shift the chain; its status result appears in the output register.
// A list of N entries yields one result per cycle, paced by the output channel.
// Reset clears the fill count and handshake state; stored cells need no clearing pass.
// A stalled output holds its result while one more input transfer is buffered.
module sorted_list_engine (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_kind,
    input  logic signed [sle_pkg::VALUE_W-1:0] i_value,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [sle_pkg::VALUE_W-1:0] o_out_value,
    output logic [sle_pkg::OCC_W-1:0]          o_occupancy,
    output logic [1:0]                         o_status,
    output logic                               o_last
);

    sle_pkg::t_cmd  cmd;
    sle_pkg::t_stat stat;

    // Sequencing and handshakes
    sle_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Ordered store and result register
    sle_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_kind      (i_kind),
        .i_value     (i_value),
        .o_stat      (stat),
        .o_out_value (o_out_value),
        .o_occupancy (o_occupancy),
        .o_status    (o_status),
        .o_last      (o_last)
    );

endmodule

FILE: hw/rtl/sle_ctrl.sv
// Controller state machine: handshakes, item sequencing and list readout pacing.
module sle_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  sle_pkg::t_stat i_stat,
    output sle_pkg::t_cmd  o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_LIST
    } t_state;

    t_state r_state, n_state;
    logic   r_cmd_valid, n_cmd_valid;
    logic   r_out_valid, n_out_valid;

    logic out_free;
    logic in_take;
    logic consumed;
    logic emit;

    assign out_free = !r_out_valid || !i_out_stall;
    assign in_take  = i_in_valid && !r_cmd_valid;

    // Command decode
    always_comb begin
        o_cmd         = '0;
        o_cmd.take_in = in_take;
        consumed      = 1'b0;
        n_state       = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (r_cmd_valid && out_free) begin
                    consumed = 1'b1;
                    unique case (i_stat.kind)
                        sle_pkg::KIND_INSERT: o_cmd.do_insert = 1'b1;
                        sle_pkg::KIND_REMOVE: o_cmd.do_remove = 1'b1;
                        sle_pkg::KIND_LIST: begin
                            if (i_stat.count_zero) begin
                                o_cmd.emit_empty = 1'b1;
                            end else begin
                                o_cmd.start_list = 1'b1;
                                n_state          = S_LIST;
                            end
                        end
                        default: ; // unused kind: dropped without a result
                    endcase
                end
            end
            S_LIST: begin
                if (out_free) begin
                    o_cmd.emit_entry = 1'b1;
                    if (i_stat.idx_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.inc_idx = 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign emit = o_cmd.do_insert || o_cmd.do_remove || o_cmd.emit_empty || o_cmd.emit_entry;

    // Holding slot and output slot occupancy
    always_comb begin
        n_cmd_valid = r_cmd_valid;
        if (in_take) begin
            n_cmd_valid = 1'b1;
        end else if (consumed) begin
            n_cmd_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (out_free) begin
            n_out_valid = 1'b0;
        end
    end

    // State and registered handshake outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cmd_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmd_valid <= n_cmd_valid;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = r_cmd_valid;
    assign o_out_valid = r_out_valid;

    // The store must not change while a readout walks it
    a_no_update_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST) |-> !(o_cmd.do_insert || o_cmd.do_remove))
        else $error("store update during list readout");

    // A waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !emit)
        else $error("result overwritten while stalled");

    // An accepted transfer lands in the holding slot
    a_take_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_cmd_valid)
        else $error("accepted transfer lost");

endmodule

FILE: hw/rtl/sle_datapath.sv
// Datapath: holding register, ordered cell chain with compare/shift, readout and result register.
module sle_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sle_pkg::t_cmd                   i_cmd,
    input  logic [1:0]                      i_kind,
    input  logic signed [sle_pkg::VALUE_W-1:0] i_value,
    output sle_pkg::t_stat                  o_stat,
    output logic signed [sle_pkg::VALUE_W-1:0] o_out_value,
    output logic [sle_pkg::OCC_W-1:0]       o_occupancy,
    output logic [1:0]                      o_status,
    output logic                            o_last
);

    localparam int N = sle_pkg::DEPTH;
    localparam int W = sle_pkg::VALUE_W;
    localparam int CW = sle_pkg::CNT_W;
    localparam int IW = sle_pkg::IDX_W;

    // Held item
    logic [1:0]          r_kind;
    logic signed [W-1:0] r_value;

    // Cell chain and fill count
    logic signed [W-1:0] r_cells [N];
    logic signed [W-1:0] n_cells [N];
    logic [CW-1:0]       r_count, n_count;
    logic [IW-1:0]       r_idx;

    // Result register
    logic signed [W-1:0] r_out_value;
    logic [CW-1:0]       r_occ;
    logic [1:0]          r_status;
    logic                r_last;

    logic [N-1:0]        ins_mask, ins_prev, ge_mask, eq_mask;
    logic signed [W-1:0] prev_cell [N];
    logic signed [W-1:0] next_cell [N];
    logic                full, found, idx_last;
    logic [1:0]          op_status;

    assign full     = (r_count == CW'(N));
    assign found    = |eq_mask;
    assign idx_last = ((CW'(r_idx) + CW'(1)) == r_count);

    // Per-cell compares against the held value
    always_comb begin
        for (int i = 0; i < N; i++) begin
            ins_mask[i] = (CW'(i) >= r_count) || (r_cells[i] > r_value);
            ge_mask[i]  = (CW'(i) >= r_count) || (r_cells[i] >= r_value);
            eq_mask[i]  = (CW'(i) < r_count) && (r_cells[i] == r_value);
        end
        prev_cell[0] = r_value;
        ins_prev[0]  = 1'b0;
        for (int i = 1; i < N; i++) begin
            prev_cell[i] = r_cells[i-1];
            ins_prev[i]  = ins_mask[i-1];
        end
        for (int i = 0; i < N - 1; i++) begin
            next_cell[i] = r_cells[i+1];
        end
        next_cell[N-1] = r_cells[N-1];
    end

    // Shift network: open a slot for insert, close the gap for remove
    always_comb begin
        n_count   = r_count;
        op_status = sle_pkg::ST_OK;
        for (int i = 0; i < N; i++) begin
            n_cells[i] = r_cells[i];
        end
        if (i_cmd.do_insert) begin
            if (full) begin
                op_status = sle_pkg::ST_FULL;
            end else begin
                n_count = r_count + CW'(1);
                for (int i = 0; i < N; i++) begin
                    if (ins_mask[i]) begin
                        n_cells[i] = ins_prev[i] ? prev_cell[i] : r_value;
                    end
                end
            end
        end else if (i_cmd.do_remove) begin
            if (!found) begin
                op_status = sle_pkg::ST_NOT_FOUND;
            end else begin
                n_count = r_count - CW'(1);
                for (int i = 0; i < N; i++) begin
                    if (ge_mask[i]) begin
                        n_cells[i] = next_cell[i];
                    end
                end
            end
        end
    end

    // Control-side registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            r_count <= n_count;
            if (i_cmd.start_list) begin
                r_idx <= '0;
            end else if (i_cmd.inc_idx) begin
                r_idx <= r_idx + IW'(1);
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_kind  <= i_kind;
            r_value <= i_value;
        end
        for (int i = 0; i < N; i++) begin
            r_cells[i] <= n_cells[i];
        end
        if (i_cmd.do_insert || i_cmd.do_remove) begin
            r_out_value <= '0;
            r_occ       <= n_count;
            r_status    <= op_status;
            r_last      <= 1'b1;
        end else if (i_cmd.emit_empty) begin
            r_out_value <= '0;
            r_occ       <= r_count;
            r_status    <= sle_pkg::ST_EMPTY;
            r_last      <= 1'b1;
        end else if (i_cmd.emit_entry) begin
            r_out_value <= r_cells[r_idx];
            r_occ       <= r_count;
            r_status    <= sle_pkg::ST_OK;
            r_last      <= idx_last;
        end
    end

    assign o_stat.kind       = r_kind;
    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.idx_last   = idx_last;

    assign o_out_value = r_out_value;
    assign o_occupancy = sle_pkg::OCC_W'(r_occ);
    assign o_status    = r_status;
    assign o_last      = r_last;

    // Fill count never passes the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(N))
        else $error("fill count beyond depth");

    // A dropped insert leaves the count alone
    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.do_insert && full) |=> $stable(r_count))
        else $error("count changed on dropped insert");

    // Readout only touches filled cells
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_entry |-> (CW'(r_idx) < r_count))
        else $error("readout index beyond fill count");

endmodule
